// File: hw/rtl/dhcp_rc_pkg.sv
// ----------------------------------------------------------------------------
// dhcp_rc_pkg
// Constants and the result layout shared by the DHCP reply classifier files.
// ----------------------------------------------------------------------------
`default_nettype none

package dhcp_rc_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_MAC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_XID        = 1'd1;

  localparam logic [1:0] PH_CODE = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_SKIP = 2'd2;
  localparam logic [1:0] PH_TYPE = 2'd3;

  localparam logic [7:0] IP_PROTO_UDP   = 8'd17;
  localparam logic [15:0] MIN_TOTAL_LEN = 16'd248;
  localparam logic [15:0] DHCP_CLIENT_PORT = 16'd68;
  localparam logic [15:0] MIN_UDP_LEN   = 16'd240;
  localparam logic [7:0] BOOTP_REPLY    = 8'd2;
  localparam logic [8:0] OPTIONS_OFFSET = 9'd248;
  localparam logic [3:0] MIN_IHL        = 4'd5;

  localparam logic [7:0] OPT_PAD      = 8'd0;
  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
  localparam logic [7:0] OPT_END      = 8'd255;

  localparam logic [7:0] MAGIC_COOKIE [4] = '{8'h63, 8'h82, 8'h53, 8'h63};

  typedef struct packed {
    logic [4:0] rsvd;
    logic       truncated;
    logic [7:0] message_type;
    logic       type_found;
    logic       for_me;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/dhcp_reply_classifier.sv
// ----------------------------------------------------------------------------
// dhcp_reply_classifier
// Byte-wide DHCP reply filter with message type extraction.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries an IPv4 packet one byte per request, starting at the IP
//   header, with tlast on its final byte. m_axis gives one verdict per
//   packet, only for the tlast byte. The cfg channel writes client_mac
//   (index 0) and transaction_id (index 1); it is always ready and must be
//   used only while no packet is in flight.
//   Verdict path: the tlast byte is held in the input register, then the
//   verdict is registered in the result register.
//   Throughput: one byte per cycle but for the stall below; the per-byte
//   compare and counter update sit between the input and result registers.
//   Stall: a held verdict stops only a following tlast byte in the input
//   register; ordinary bytes keep flowing. Bytes past MAX_PACKET_BYTES are
//   ignored, but their tlast still produces a verdict.
//   Reset: clears valid flags, cfg and all per-packet state; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module dhcp_reply_classifier #(
  parameter int unsigned MAX_PACKET_BYTES = 2048
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [7:0]                         s_axis_tdata,  // data_byte
  input  wire logic                               s_axis_tlast,  // last_byte
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // for_me, type_found, message_type[7:0], truncated, zero pad[4:0]
  output logic [15:0]                             m_axis_tdata,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [dhcp_rc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [47:0]                        cfg_data_i
);
  import dhcp_rc_pkg::*;

  localparam int unsigned OFF_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [OFF_W-1:0] MAX_OFF = OFF_W'(MAX_PACKET_BYTES);

  logic [47:0] mac_q;
  logic [31:0] xid_q;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  logic       out_valid_q;
  result_t    out_q;

  logic [OFF_W-1:0] off_q, off_d;
  logic [3:0]       hw_q, hw_d;
  logic [7:0]       ls_q, ls_d;
  logic             ok_q, ok_d;
  logic [1:0]       ph_q, ph_d;
  logic [7:0]       skip_q, skip_d;
  logic             done_q, done_d;
  logic             fnd_q, fnd_d;
  logic [7:0]       typ_q, typ_d;

  logic             out_free;
  logic             adv;
  logic [OFF_W-1:0] hw4;
  logic [OFF_W-1:0] r;
  logic [15:0]      pair;
  logic [8:0]       opt_start;
  logic             reached;
  result_t          res;

  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || adv;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  assign hw4  = OFF_W'({hw_q, 2'b00});
  assign r    = off_q - hw4;
  assign pair = {ls_q, in_byte_q};

  always_comb begin
    off_d  = off_q;
    hw_d   = hw_q;
    ls_d   = ls_q;
    ok_d   = ok_q;
    ph_d   = ph_q;
    skip_d = skip_q;
    done_d = done_q;
    fnd_d  = fnd_q;
    typ_d  = typ_q;
    if (off_q < MAX_OFF) begin
      off_d = off_q + OFF_W'(1);
      if (off_q == '0) begin
        hw_d = in_byte_q[3:0];
        if (in_byte_q[3:0] < MIN_IHL) begin
          ok_d = 1'b0;
        end
      end else begin
        if (off_q == OFF_W'(2)) begin
          ls_d = in_byte_q;
        end else if (off_q == OFF_W'(3)) begin
          if (pair < MIN_TOTAL_LEN) ok_d = 1'b0;
        end else if (off_q == OFF_W'(9)) begin
          if (in_byte_q != IP_PROTO_UDP) ok_d = 1'b0;
        end
        if (hw_q >= MIN_IHL && off_q >= hw4) begin
          if (r == OFF_W'(2) || r == OFF_W'(4)) begin
            ls_d = in_byte_q;
          end else if (r == OFF_W'(3)) begin
            if (pair != DHCP_CLIENT_PORT) ok_d = 1'b0;
          end else if (r == OFF_W'(5)) begin
            if (pair < MIN_UDP_LEN) ok_d = 1'b0;
          end else if (r == OFF_W'(8)) begin
            if (in_byte_q != BOOTP_REPLY) ok_d = 1'b0;
          end else if (r >= OFF_W'(12) && r <= OFF_W'(15)) begin
            case (r[1:0])
              2'd0:    if (xid_q[31:24] != in_byte_q) ok_d = 1'b0;
              2'd1:    if (xid_q[23:16] != in_byte_q) ok_d = 1'b0;
              2'd2:    if (xid_q[15:8]  != in_byte_q) ok_d = 1'b0;
              default: if (xid_q[7:0]   != in_byte_q) ok_d = 1'b0;
            endcase
          end else if (r >= OFF_W'(36) && r <= OFF_W'(41)) begin
            case (3'(r - OFF_W'(36)))
              3'd0:    if (mac_q[47:40] != in_byte_q) ok_d = 1'b0;
              3'd1:    if (mac_q[39:32] != in_byte_q) ok_d = 1'b0;
              3'd2:    if (mac_q[31:24] != in_byte_q) ok_d = 1'b0;
              3'd3:    if (mac_q[23:16] != in_byte_q) ok_d = 1'b0;
              3'd4:    if (mac_q[15:8]  != in_byte_q) ok_d = 1'b0;
              default: if (mac_q[7:0]   != in_byte_q) ok_d = 1'b0;
            endcase
          end else if (r >= OFF_W'(244) && r <= OFF_W'(247)) begin
            if (MAGIC_COOKIE[r[1:0]] != in_byte_q) ok_d = 1'b0;
          end else if (r >= OFF_W'(248) && !done_q) begin
            case (ph_q)
              PH_CODE: begin
                if (in_byte_q == OPT_END) begin
                  done_d = 1'b1;
                end else if (in_byte_q == OPT_MSG_TYPE) begin
                  ph_d   = PH_TYPE;
                  skip_d = '0;
                end else if (in_byte_q != OPT_PAD) begin
                  ph_d = PH_LEN;
                end
              end
              PH_LEN: begin
                skip_d = in_byte_q;
                ph_d   = (in_byte_q != 8'd0) ? PH_SKIP : PH_CODE;
              end
              PH_SKIP: begin
                skip_d = skip_q - 8'd1;
                if (skip_q == 8'd1) ph_d = PH_CODE;
              end
              default: begin
                if (skip_q == 8'd0) begin
                  skip_d = 8'd1;
                end else begin
                  fnd_d  = 1'b1;
                  typ_d  = in_byte_q;
                  done_d = 1'b1;
                end
              end
            endcase
          end
        end
      end
    end
  end

  assign opt_start = {3'b000, hw_d, 2'b00} + OPTIONS_OFFSET;
  assign reached   = off_d >= OFF_W'(opt_start);

  always_comb begin
    res              = '0;
    res.for_me       = ok_d && reached;
    res.type_found   = ok_d && reached && fnd_d;
    res.message_type = (ok_d && reached && fnd_d) ? typ_d : 8'd0;
    res.truncated    = !reached;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_q <= '0;
      xid_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CLIENT_MAC: mac_q <= cfg_data_i;
        CFG_XID:        xid_q <= cfg_data_i[31:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q  <= '0;
      hw_q   <= '0;
      ls_q   <= '0;
      ok_q   <= 1'b1;
      ph_q   <= PH_CODE;
      skip_q <= '0;
      done_q <= 1'b0;
      fnd_q  <= 1'b0;
      typ_q  <= '0;
    end else if (adv) begin
      if (in_last_q) begin
        off_q  <= '0;
        hw_q   <= '0;
        ls_q   <= '0;
        ok_q   <= 1'b1;
        ph_q   <= PH_CODE;
        skip_q <= '0;
        done_q <= 1'b0;
        fnd_q  <= 1'b0;
        typ_q  <= '0;
      end else begin
        off_q  <= off_d;
        hw_q   <= hw_d;
        ls_q   <= ls_d;
        ok_q   <= ok_d;
        ph_q   <= ph_d;
        skip_q <= skip_d;
        done_q <= done_d;
        fnd_q  <= fnd_d;
        typ_q  <= typ_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= adv && in_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && adv && in_last_q) begin
      out_q <= res;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dhcp_rc_checker.sv
// ----------------------------------------------------------------------------
// dhcp_rc_checker
// Port-level checks for the DHCP reply classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dhcp_rc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);
  import dhcp_rc_pkg::*;

  result_t res;
  logic    last_req;

  assign res      = m_axis_tdata;
  assign last_req = s_axis_tvalid && s_axis_tready && s_axis_tlast;

  a_type_needs_me: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!res.type_found || res.for_me))
    else $error("type_found without for_me");

  a_type_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !res.type_found) |-> (res.message_type == 8'd0))
    else $error("message_type set without type_found");

  a_trunc_not_me: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.truncated) |-> !res.for_me)
    else $error("truncated packet marked for_me");

  a_verdict_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(last_req, 2))
    else $error("verdict without a last byte two cycles earlier");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled verdict changed");

endmodule

bind dhcp_reply_classifier dhcp_rc_checker u_dhcp_rc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: tb/sv/tb_dhcp_reply_classifier.sv
// ----------------------------------------------------------------------------
// tb_dhcp_reply_classifier
// Self-checking bench for the DHCP reply classifier. Directed and random IPv4
// packets are streamed byte by byte with random gaps and receiver stalls. A
// behavioural predictor works out the verdict of every packet, and each
// verdict from the block is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_dhcp_reply_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  import dhcp_rc_pkg::*;

  localparam int unsigned MAX_BYTES     = 2048;
  localparam int unsigned HOLD_CYCLES   = 400;

  typedef logic [7:0] octets_t[$];

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = CFG_CLIENT_MAC;
  logic [47:0]          cfg_data_i    = '0;

  // stimulus side copy of the registers, used to build matching replies
  logic [47:0] mac_now = '0;
  logic [31:0] xid_now = '0;

  beat_t   beat_q[$];
  result_t verdicts_due[$];
  bit      steady_tx = 1'b0;
  bit      steady_rx = 1'b0;
  int unsigned holds_asked = 0;
  int unsigned holds_done  = 0;
  int unsigned hold_left   = 0;
  int unsigned mismatches  = 0;

  // predictor state
  logic [47:0] own_mac = '0;
  logic [31:0] own_xid = '0;
  logic [11:0] pk_count;
  logic [3:0]  pk_ihl;
  logic [7:0]  pk_hi;
  bit          pk_ok;
  logic [1:0]  opt_phase;
  logic [7:0]  opt_skip;
  bit          opt_done;
  bit          type_seen;
  logic [7:0]  type_val;

  dhcp_reply_classifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic void restart_packet();
    pk_count  = '0;
    pk_ihl    = '0;
    pk_hi     = '0;
    pk_ok     = 1'b1;
    opt_phase = PH_CODE;
    opt_skip  = '0;
    opt_done  = 1'b0;
    type_seen = 1'b0;
    type_val  = '0;
  endfunction

  function automatic bit classify_byte(input logic [7:0] b, input logic last,
                                       output result_t verdict);
    int unsigned n, r, hdr;
    bit reached;
    verdict = '0;
    if (pk_count < MAX_BYTES) begin
      n   = pk_count;
      hdr = 4 * pk_ihl;
      pk_count++;
      if (n == 0) begin
        pk_ihl = b[3:0];
        if (b[3:0] < MIN_IHL) pk_ok = 1'b0;
      end else begin
        if (n == 2) begin
          pk_hi = b;
        end else if (n == 3) begin
          if ({pk_hi, b} < MIN_TOTAL_LEN) pk_ok = 1'b0;
        end else if (n == 9) begin
          if (b != IP_PROTO_UDP) pk_ok = 1'b0;
        end
        if (pk_ihl >= MIN_IHL && n >= hdr) begin
          r = n - hdr;
          if (r == 2 || r == 4) begin
            pk_hi = b;
          end else if (r == 3) begin
            if ({pk_hi, b} != DHCP_CLIENT_PORT) pk_ok = 1'b0;
          end else if (r == 5) begin
            if ({pk_hi, b} < MIN_UDP_LEN) pk_ok = 1'b0;
          end else if (r == 8) begin
            if (b != BOOTP_REPLY) pk_ok = 1'b0;
          end else if (r >= 12 && r <= 15) begin
            if (own_xid[8*(15-r) +: 8] != b) pk_ok = 1'b0;
          end else if (r >= 36 && r <= 41) begin
            if (own_mac[8*(41-r) +: 8] != b) pk_ok = 1'b0;
          end else if (r >= OPTIONS_OFFSET - 4 && r < OPTIONS_OFFSET) begin
            if (MAGIC_COOKIE[r-(OPTIONS_OFFSET-4)] != b) pk_ok = 1'b0;
          end else if (r >= OPTIONS_OFFSET && !opt_done) begin
            case (opt_phase)
              PH_CODE: begin
                if (b == OPT_END) begin
                  opt_done = 1'b1;
                end else if (b == OPT_MSG_TYPE) begin
                  opt_phase = PH_TYPE;
                  opt_skip  = '0;
                end else if (b != OPT_PAD) begin
                  opt_phase = PH_LEN;
                end
              end
              PH_LEN: begin
                opt_skip  = b;
                opt_phase = (b != 0) ? PH_SKIP : PH_CODE;
              end
              PH_SKIP: begin
                opt_skip = opt_skip - 8'd1;
                if (opt_skip == 0) opt_phase = PH_CODE;
              end
              default: begin
                if (opt_skip == 0) begin
                  opt_skip = 8'd1;
                end else begin
                  type_seen = 1'b1;
                  type_val  = b;
                  opt_done  = 1'b1;
                end
              end
            endcase
          end
        end
      end
    end
    if (!last) return 1'b0;
    reached              = pk_count >= 4 * pk_ihl + OPTIONS_OFFSET;
    verdict.for_me       = pk_ok && reached;
    verdict.type_found   = verdict.for_me && type_seen;
    verdict.message_type = verdict.type_found ? type_val : 8'd0;
    verdict.truncated    = !reached;
    restart_packet();
    return 1'b1;
  endfunction

  function automatic void note_mismatch(input string what, input result_t want,
                                        input result_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: verdict %s: expected me=%0b found=%0b type=%02h trunc=%0b pad=%02h",
               $time, what, want.for_me, want.type_found, want.message_type,
               want.truncated, want.rsvd);
      $display("%0t:                 actual   me=%0b found=%0b type=%02h trunc=%0b pad=%02h",
               $time, seen.for_me, seen.type_found, seen.message_type,
               seen.truncated, seen.rsvd);
    end
  endfunction

  function automatic octets_t reply_frame(input int unsigned ihl);
    octets_t     f;
    int unsigned hdr, i;
    logic [15:0] len16;
    hdr = 4 * ihl;
    for (i = 0; i < hdr + OPTIONS_OFFSET; i++) f.push_back(8'($urandom));
    f[0]  = {4'h4, 4'(ihl)};
    len16 = ($urandom_range(3) == 0) ? MIN_TOTAL_LEN
                                     : 16'($urandom_range(MIN_TOTAL_LEN, 16'hFFFF));
    f[2]  = len16[15:8];
    f[3]  = len16[7:0];
    f[9]  = IP_PROTO_UDP;
    f[hdr+2] = DHCP_CLIENT_PORT[15:8];
    f[hdr+3] = DHCP_CLIENT_PORT[7:0];
    len16 = ($urandom_range(3) == 0) ? MIN_UDP_LEN
                                     : 16'($urandom_range(MIN_UDP_LEN, 16'hFFFF));
    f[hdr+4] = len16[15:8];
    f[hdr+5] = len16[7:0];
    f[hdr+8] = BOOTP_REPLY;
    for (i = 0; i < 4; i++) f[hdr+12+i] = xid_now[8*(3-i) +: 8];
    for (i = 0; i < 6; i++) f[hdr+36+i] = mac_now[8*(5-i) +: 8];
    for (i = 0; i < 4; i++) f[hdr+OPTIONS_OFFSET-4+i] = MAGIC_COOKIE[i];
    return f;
  endfunction

  function automatic void offer_packet(input octets_t f);
    int unsigned i;
    for (i = 0; i < f.size(); i++) beat_q.push_back('{data: f[i], last: i == f.size() - 1});
  endfunction

  task automatic random_packet();
    octets_t     f;
    int unsigned ihl, hdr, len, code, pick;
    ihl = ($urandom_range(3) == 0) ? $urandom_range(MIN_IHL, 15) : MIN_IHL;
    hdr = 4 * ihl;
    f   = reply_frame(ihl);
    repeat ($urandom_range(6)) begin
      case ($urandom_range(9))
        0, 1: f.push_back(OPT_PAD);
        2, 3: begin
          len = $urandom_range(3);
          f.push_back(OPT_MSG_TYPE);
          f.push_back(8'(len));
          f.push_back(8'($urandom));
          repeat ((len > 1) ? len - 1 : 0) f.push_back(8'($urandom));
        end
        4: f.push_back(OPT_END);
        default: begin
          code = $urandom_range(1, 254);
          if (code == OPT_MSG_TYPE) code++;
          len = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(8);
          f.push_back(8'(code));
          f.push_back(8'(len));
          repeat (len) f.push_back(8'($urandom));
        end
      endcase
    end
    pick = $urandom_range(99);
    if (pick >= 55 && pick < 80) begin
      case ($urandom_range(8))
        0: f[0] = {4'h4, 4'($urandom_range(MIN_IHL - 1))};
        1: begin
          f[2] = 8'd0;
          f[3] = 8'($urandom_range(MIN_TOTAL_LEN - 1));
        end
        2: f[9] ^= 8'($urandom_range(1, 255));
        3: f[hdr+2+$urandom_range(1)] ^= 8'($urandom_range(1, 255));
        4: begin
          f[hdr+4] = 8'd0;
          f[hdr+5] = 8'($urandom_range(MIN_UDP_LEN - 1));
        end
        5: f[hdr+8] ^= 8'($urandom_range(1, 255));
        6: f[hdr+12+$urandom_range(3)] ^= 8'($urandom_range(1, 255));
        7: f[hdr+36+$urandom_range(5)] ^= 8'($urandom_range(1, 255));
        default: f[hdr+OPTIONS_OFFSET-4+$urandom_range(3)] ^= 8'($urandom_range(1, 255));
      endcase
    end else if (pick >= 80 && pick < 90) begin
      f = f[0:$urandom_range(f.size() - 1)];
    end else if (pick >= 90) begin
      f.delete();
      repeat ($urandom_range(1, 40)) f.push_back(8'($urandom));
    end
    offer_packet(f);
  endtask

  task automatic settle();
    do @(posedge clk_i);
    while (beat_q.size() != 0 || s_axis_tvalid || verdicts_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] value);
    @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_CLIENT_MAC) mac_now = value;
    else xid_now = value[31:0];
  endtask

  task automatic write_random_registers();
    write_register(CFG_CLIENT_MAC, 48'({$urandom, $urandom}));
    write_register(CFG_XID, 48'($urandom));
  endtask

  // sender: advance to the next byte once the current one is taken
  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (beat_q.size() != 0 && (steady_tx || $urandom_range(99) >= 29)) begin
        s_axis_tdata  <= beat_q[0].data;
        s_axis_tlast  <= beat_q[0].last;
        s_axis_tvalid <= 1'b1;
        void'(beat_q.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (holds_done != holds_asked) begin
        holds_done    <= holds_done + 1;
        hold_left     <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady_rx || $urandom_range(99) >= 29;
      end
    end
  end

  always @(posedge clk_i) begin : watch_requests
    result_t verdict;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_CLIENT_MAC) own_mac = cfg_data_i;
        else own_xid = cfg_data_i[31:0];
      end
      if (s_axis_tvalid && s_axis_tready &&
          classify_byte(s_axis_tdata, s_axis_tlast, verdict))
        verdicts_due.push_back(verdict);
    end
  end

  always @(posedge clk_i) begin : watch_verdicts
    result_t seen, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = m_axis_tdata;
      if (verdicts_due.size() == 0) begin
        note_mismatch("unexpected", '0, seen);
      end else begin
        want = verdicts_due.pop_front();
        if (seen.for_me !== want.for_me || seen.type_found !== want.type_found ||
            seen.message_type !== want.message_type ||
            seen.truncated !== want.truncated || seen.rsvd !== want.rsvd)
          note_mismatch("mismatch  ", want, seen);
      end
    end
  end

  initial begin : stimulus
    octets_t f;
    restart_packet();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_register(CFG_CLIENT_MAC, '0);
    write_register(CFG_XID, '0);

    f = '{8'h45};
    offer_packet(f);
    f = reply_frame(MIN_IHL);
    f = {f, OPT_PAD, OPT_PAD, OPT_PAD, OPT_MSG_TYPE, 8'd1, 8'hFF};
    offer_packet(f);
    f = reply_frame(15);
    f = {f, 8'd12, 8'd3, 8'hA5, 8'h5A, 8'hFF, OPT_MSG_TYPE, 8'd0, 8'd2};
    offer_packet(f);
    settle();

    write_register(CFG_CLIENT_MAC, '1);
    write_register(CFG_XID, '1);
    random_packet();
    settle();

    // hold the verdict side while short packets keep arriving
    write_random_registers();
    holds_asked++;
    repeat (30) begin
      f.delete();
      repeat ($urandom_range(1, 3)) f.push_back(8'($urandom));
      offer_packet(f);
    end
    random_packet();
    settle();

    write_random_registers();
    steady_tx = 1'b1;
    steady_rx = 1'b1;
    random_packet();
    settle();
    steady_tx = 1'b0;
    steady_rx = 1'b0;

    write_random_registers();
    random_packet();
    settle();
    repeat (8) @(posedge clk_i);

    mismatches += verdicts_due.size();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #4ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
